[hw/rtl/dhcp_option_scanner_unit_macros.svh]
// Assertion macros used by the DHCP option scanner checker.
`ifndef DHCP_OPTION_SCANNER_UNIT_MACROS_SVH
`define DHCP_OPTION_SCANNER_UNIT_MACROS_SVH

// Clocked assertion, inactive while reset is asserted.
`define DOS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DOS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/dos_pkg.sv]
// Types and constants for the DHCP option scanner.
`default_nettype none

package dos_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OFFS_W = 11;
    localparam int unsigned STAT_W = 3;

    localparam logic [BYTE_W-1:0] CODE_PAD = 8'd0;
    localparam logic [BYTE_W-1:0] CODE_END = 8'd255;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_CODE    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_VALUE   = 3'd3,
        PH_SETTLED = 3'd4
    } dos_phase_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND      = 3'd0,
        ST_END        = 3'd1,
        ST_SHORT      = 3'd2,
        ST_TRUNC      = 3'd3,
        ST_DATA_ENDED = 3'd4
    } dos_status_t;

    // One search result; status sits in the low bits
    typedef struct packed {
        logic [BYTE_W-1:0] length;
        logic [OFFS_W-1:0] offset;
        dos_status_t       status;
    } dos_result_t;

endpackage

`default_nettype wire

[hw/rtl/dhcp_option_scanner_unit.sv]
// DHCP option scanner: finds one configured option in a byte-serial DHCP message.
//
// Input stream (s_*): one message byte per transaction, s_tlast on the final byte.
// The first HEADER_BYTES bytes are skipped, then the option list is walked as
// code/length/value records; pad is skipped and the end code settles the search.
// Config channel (cfg_*): cfg_data is the option code to look for; cfg_ready is
// always high, and a write should land between messages.
// Result stream (m_*): exactly one transaction per message, after its last byte:
// status, offset of the option's code byte in the options field, and value length
// (offset and length are zero unless the option was found).
// The result is registered into the output buffer from the last byte's parser update.
// Throughput: one byte per cycle while s_tready is high, set by the parser update.
// A two-entry output buffer (result register plus skid) lets input keep flowing
// while a result waits; s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous) clears the parser, empties the output buffer
// and sets the wanted code to zero.
`default_nettype none

module dhcp_option_scanner_unit #(
    parameter int unsigned HEADER_BYTES  = 240,
    parameter int unsigned MAX_MSG_BYTES = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] status, [13:3] option_offset,
                                        // [21:14] option_length, [23:22] zero
    // Configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // wanted_code
);
    import dos_pkg::*;

    logic [BYTE_W-1:0] wanted_reg;
    logic              byte_accept;
    logic              res_valid;
    dos_result_t       res;

    logic              main_valid_reg, main_valid_next;
    dos_result_t       main_data_reg, main_data_next;
    logic              skid_valid_reg, skid_valid_next;
    dos_result_t       skid_data_reg, skid_data_next;
    logic              pop;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !skid_valid_reg;
    assign byte_accept = s_tvalid && s_tready;

    // Hold the wanted option code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            wanted_reg <= cfg_data;
        end
    end

    dos_parser #(
        .HEADER_BYTES  (HEADER_BYTES),
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .data_byte   (s_tdata),
        .last_byte   (s_tlast),
        .wanted_code (wanted_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output buffer: result register backed by a skid entry
    assign pop = main_valid_reg && m_tready;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (res_valid) begin
                main_data_next = res;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {2'b00, main_data_reg.length, main_data_reg.offset,
                       main_data_reg.status};

endmodule

`default_nettype wire

[hw/rtl/dos_parser.sv]
// Byte-wise option list parser: one message byte per accepted transaction.
`default_nettype none

module dos_parser #(
    parameter int unsigned HEADER_BYTES  = 240,
    parameter int unsigned MAX_MSG_BYTES = 2048
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       byte_accept,
    input  wire logic [dos_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       last_byte,
    input  wire logic [dos_pkg::BYTE_W-1:0] wanted_code,
    output logic                            res_valid,
    output dos_pkg::dos_result_t            res
);
    import dos_pkg::*;

    localparam int unsigned POS_W  = $clog2(MAX_MSG_BYTES + 1);
    localparam int unsigned DIFF_W = (POS_W > OFFS_W) ? POS_W : OFFS_W;

    dos_phase_t        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] skip_reg, skip_next;
    logic              pend_reg, pend_next;
    logic [OFFS_W-1:0] moff_reg, moff_next;
    logic [BYTE_W-1:0] mlen_reg, mlen_next;
    dos_status_t       sst_reg, sst_next;

    logic [DIFF_W-1:0] pos_wide;
    logic [DIFF_W-1:0] code_offset;
    logic              header_done;
    logic              in_window;
    dos_status_t       final_status;

    assign pos_wide    = DIFF_W'(pos_reg);
    assign code_offset = pos_wide - DIFF_W'(HEADER_BYTES);
    assign header_done = (pos_wide >= DIFF_W'(HEADER_BYTES - 1));
    assign in_window   = (pos_reg < POS_W'(MAX_MSG_BYTES));

    // Advance the parser on each accepted byte within the parse limit; report and clear on the last one
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        skip_next    = skip_reg;
        pend_next    = pend_reg;
        moff_next    = moff_reg;
        mlen_next    = mlen_reg;
        sst_next     = sst_reg;
        final_status = ST_DATA_ENDED;
        res_valid    = 1'b0;
        res          = '0;

        if (byte_accept) begin
            if (in_window) begin
                pos_next = pos_reg + 1'b1;
                case (phase_reg)
                    PH_HEADER: begin
                        if (header_done) begin
                            phase_next = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        if (data_byte == CODE_PAD) begin
                            phase_next = PH_CODE;
                        end else if (data_byte == CODE_END) begin
                            sst_next   = ST_END;
                            phase_next = PH_SETTLED;
                        end else begin
                            pend_next  = (data_byte == wanted_code);
                            moff_next  = code_offset[OFFS_W-1:0];
                            phase_next = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        mlen_next = data_byte;
                        skip_next = data_byte;
                        if (data_byte == '0) begin
                            if (pend_reg) begin
                                sst_next   = ST_FOUND;
                                phase_next = PH_SETTLED;
                            end else begin
                                phase_next = PH_CODE;
                            end
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_reg == BYTE_W'(1)) begin
                            if (pend_reg) begin
                                sst_next   = ST_FOUND;
                                phase_next = PH_SETTLED;
                            end else begin
                                phase_next = PH_CODE;
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            if (last_byte) begin
                case (phase_next)
                    PH_SETTLED: final_status = sst_next;
                    PH_HEADER:  final_status = ST_SHORT;
                    PH_CODE:    final_status = ST_DATA_ENDED;
                    default:    final_status = ST_TRUNC;
                endcase
                res_valid  = 1'b1;
                res.status = final_status;
                if (final_status == ST_FOUND) begin
                    res.offset = moff_next;
                    res.length = mlen_next;
                end
                // Drop all per-message state
                phase_next = PH_HEADER;
                pos_next   = '0;
                skip_next  = '0;
                pend_next  = 1'b0;
                moff_next  = '0;
                mlen_next  = '0;
                sst_next   = ST_DATA_ENDED;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            skip_reg  <= '0;
            pend_reg  <= 1'b0;
            moff_reg  <= '0;
            mlen_reg  <= '0;
            sst_reg   <= ST_DATA_ENDED;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            pend_reg  <= pend_next;
            moff_reg  <= moff_next;
            mlen_reg  <= mlen_next;
            sst_reg   <= sst_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dos_checker.sv]
// Port-level checks for the DHCP option scanner, bound to the top level.
`default_nettype none
`include "dhcp_option_scanner_unit_macros.svh"

module dos_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata
);
    import dos_pkg::*;

    // A stalled result transaction keeps its payload
    `DOS_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Status is one of the defined codes
    `DOS_ASSERT(a_status_range, aclk, aresetn, m_tvalid |-> m_tdata[2:0] <= ST_DATA_ENDED, "status out of range")

    // Offset and length are zero unless the option was found
    `DOS_ASSERT(a_zero_unless_found, aclk, aresetn, m_tvalid && m_tdata[2:0] != ST_FOUND |-> m_tdata[21:3] == '0, "nonzero fields on a miss")

    // Reset empties the output buffer
    `DOS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind dhcp_option_scanner_unit dos_checker u_dos_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/dhcp_option_scanner_unit_tb.sv]
// Testbench for the DHCP option scanner: directed and random messages checked by a predictor.
module dhcp_option_scanner_unit_tb;
    import dos_pkg::*;

    localparam int unsigned HEADER_LEN      = 240;
    localparam int unsigned PARSE_LIMIT     = 2048;
    localparam int unsigned CLK_PERIOD      = 12;
    localparam int unsigned TIMEOUT_CYCLES  = 8_000_000;
    localparam int unsigned RANDOM_MESSAGES = 40;
    localparam int unsigned REPORT_LIMIT    = 10;

    // Predict the search result of each message and check the result stream against it
    class option_search_scoreboard;
        logic [7:0]  wanted;
        dos_phase_t  phase;
        int unsigned position;
        logic [7:0]  skip_left;
        bit          code_hit;
        logic [10:0] hit_offset;
        logic [7:0]  hit_length;
        dos_status_t settled;
        dos_result_t expected_q[$];
        int unsigned mismatches;

        function new();
            wanted     = 8'd0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_HEADER;
            position   = 0;
            skip_left  = 8'd0;
            code_hit   = 1'b0;
            hit_offset = '0;
            hit_length = 8'd0;
            settled    = ST_DATA_ENDED;
        endfunction

        function void set_wanted(logic [7:0] code);
            wanted = code;
        endfunction

        function void settle(dos_status_t st);
            settled = st;
            phase   = PH_SETTLED;
        endfunction

        // Finish a code/length/value record: stop on a hit, else look for the next code
        function void close_record();
            if (code_hit) begin
                settle(ST_FOUND);
            end else begin
                phase = PH_CODE;
            end
        endfunction

        // Advance the parser by one accepted byte; queue the result on the last one
        function void note_byte(logic [7:0] b, logic last);
            dos_result_t res;
            if (position < PARSE_LIMIT) begin
                position++;
                case (phase)
                    PH_HEADER: begin
                        if (position >= HEADER_LEN) phase = PH_CODE;
                    end
                    PH_CODE: begin
                        if (b == CODE_END) begin
                            settle(ST_END);
                        end else if (b != CODE_PAD) begin
                            code_hit   = (b == wanted);
                            hit_offset = 11'(position - 1 - HEADER_LEN);
                            phase      = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        hit_length = b;
                        skip_left  = b;
                        if (b != 8'd0) begin
                            phase = PH_VALUE;
                        end else begin
                            close_record();
                        end
                    end
                    PH_VALUE: begin
                        skip_left--;
                        if (skip_left == 8'd0) close_record();
                    end
                    default: ;
                endcase
            end
            if (last) begin
                case (phase)
                    PH_SETTLED: res.status = settled;
                    PH_HEADER:  res.status = ST_SHORT;
                    PH_CODE:    res.status = ST_DATA_ENDED;
                    default:    res.status = ST_TRUNC;
                endcase
                res.offset = (res.status == ST_FOUND) ? hit_offset : '0;
                res.length = (res.status == ST_FOUND) ? hit_length : 8'd0;
                expected_q.push_back(res);
                restart();
            end
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_result(logic [23:0] data);
            dos_result_t got;
            dos_result_t want;
            got = data[21:0];
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result: status %0d offset %0d length %0d",
                                 got.status, got.offset, got.length));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.offset !== want.offset ||
                got.length !== want.length || data[23:22] !== 2'b00) begin
                report($sformatf("expected status %0d offset %0d length %0d, got %0d %0d %0d pad %0d",
                                 want.status, want.offset, want.length,
                                 got.status, got.offset, got.length, data[23:22]));
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] data_byte
    logic        s_tlast   = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [2:0] status, [13:3] option_offset,
                                     // [21:14] option_length, [23:22] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'd0;   // wanted_code

    option_search_scoreboard board;
    logic [7:0]  msg_bytes[$];
    int unsigned send_gap_max = 19;
    int unsigned recv_gap_max = 19;

    dhcp_option_scanner_unit #(
        .HEADER_BYTES  (HEADER_LEN),
        .MAX_MSG_BYTES (PARSE_LIMIT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    function automatic void add_noise(int unsigned n);
        repeat (n) msg_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_option(logic [7:0] code, logic [7:0] len);
        msg_bytes.push_back(code);
        msg_bytes.push_back(len);
        repeat (len) msg_bytes.push_back(8'($urandom));
    endfunction

    // Mostly short values, sometimes empty, sometimes near the 255-byte maximum
    function automatic logic [7:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            9:       return 8'($urandom_range(200, 255));
            default: return 8'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic void add_record(logic [7:0] wanted);
        case ($urandom_range(0, 15))
            0, 1, 2: msg_bytes.push_back(CODE_PAD);
            3:       msg_bytes.push_back(CODE_END);
            4, 5, 6: add_option(wanted, pick_length());
            default: add_option(8'($urandom_range(1, 254)), pick_length());
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return CODE_PAD;
            1:       return CODE_END;
            2:       return 8'd1;
            3:       return 8'd254;
            default: return 8'($urandom_range(1, 254));
        endcase
    endfunction

    function automatic int unsigned pick_gap_max();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 19;
        endcase
    endfunction

    // Hold until every result is back and the parser has settled
    task automatic wait_idle();
        while (board.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_wanted(logic [7:0] code);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge aclk); while (!cfg_ready);
        board.set_wanted(code);
        cfg_valid <= 1'b0;
    endtask

    // Drive one byte transaction after a random gap
    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_byte(b, last);
    endtask

    // Send the built message, optionally reprogramming the wanted code first
    task automatic send_message(bit reconfig, logic [7:0] code);
        if (reconfig) begin
            s_tvalid <= 1'b0;
            wait_idle();
            write_wanted(code);
        end
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Accept result transactions with random stalls
    initial begin : result_sink
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, recv_gap_max);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

    initial begin : stimulus
        logic [7:0]  code;
        int unsigned shape;
        int unsigned cut;
        bit          reconfig;
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Short header: ends on the first byte, then one byte before the options
        msg_bytes.delete(); add_noise(1);
        send_message(1, 8'd1);
        msg_bytes.delete(); add_noise(HEADER_LEN - 1);
        send_message(1, 8'd254);

        // Header only: empty options field
        msg_bytes.delete(); add_noise(HEADER_LEN);
        send_message(0, 8'd0);

        // End option, then bytes to be ignored
        msg_bytes.delete(); add_noise(HEADER_LEN);
        msg_bytes.push_back(CODE_END); add_noise(3);
        send_message(1, 8'd53);

        // Found after pads and another option, trailing bytes ignored
        msg_bytes.delete(); add_noise(HEADER_LEN);
        msg_bytes.push_back(CODE_PAD); msg_bytes.push_back(CODE_PAD);
        add_option(8'd12, 8'd2); add_option(8'd53, 8'd3); add_noise(4);
        send_message(0, 8'd53);

        // Zero-length match
        msg_bytes.delete(); add_noise(HEADER_LEN);
        add_option(8'd53, 8'd0);
        send_message(0, 8'd53);

        // Options run out without a match
        msg_bytes.delete(); add_noise(HEADER_LEN);
        add_option(8'd7, 8'd2); add_option(8'd9, 8'd0);
        send_message(0, 8'd53);

        // Message ends right after a code byte
        msg_bytes.delete(); add_noise(HEADER_LEN);
        add_option(8'd12, 8'd1); msg_bytes.push_back(8'd53);
        send_message(0, 8'd53);

        // Value runs past the last byte, matching and not matching
        msg_bytes.delete(); add_noise(HEADER_LEN);
        msg_bytes.push_back(8'd53); msg_bytes.push_back(8'd5); add_noise(2);
        send_message(0, 8'd53);
        msg_bytes.delete(); add_noise(HEADER_LEN);
        msg_bytes.push_back(8'd7); msg_bytes.push_back(8'd9); add_noise(1);
        send_message(0, 8'd53);

        // Pad as wanted code never matches
        msg_bytes.delete(); add_noise(HEADER_LEN);
        msg_bytes.push_back(CODE_PAD); msg_bytes.push_back(CODE_PAD);
        add_option(8'd3, 8'd1); msg_bytes.push_back(CODE_END);
        send_message(1, CODE_PAD);

        // End as wanted code never matches
        msg_bytes.delete(); add_noise(HEADER_LEN);
        add_option(8'd254, 8'd2); msg_bytes.push_back(CODE_END); add_noise(2);
        send_message(1, CODE_END);

        // Longest value on the top code
        msg_bytes.delete(); add_noise(HEADER_LEN);
        add_option(8'd254, 8'd255); add_noise(2);
        send_message(1, 8'd254);

        // Back-to-back one-byte messages against a stalled result side
        send_gap_max = 0;
        repeat (8) begin
            msg_bytes.delete(); add_noise(1);
            send_message(0, 8'd0);
        end
        send_gap_max = 19;

        // Overlong messages: a match that fits before the parse limit, one that does not
        msg_bytes.delete(); add_noise(HEADER_LEN);
        repeat (7) add_option(8'd1, 8'd253);
        add_option(8'h80, 8'd10); add_noise(60);
        send_message(1, 8'h80);
        msg_bytes.delete(); add_noise(HEADER_LEN);
        repeat (7) add_option(8'd1, 8'd253);
        add_option(8'h80, 8'd30); add_noise(20);
        send_message(0, 8'h80);

        // Random messages: mostly well-formed option lists, some noise and cut messages
        for (int m = 0; m < RANDOM_MESSAGES; m++) begin
            send_gap_max = pick_gap_max();
            recv_gap_max = pick_gap_max();
            reconfig = ($urandom_range(0, 3) != 0);
            code = reconfig ? pick_code() : board.wanted;
            msg_bytes.delete();
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                add_noise($urandom_range(1, 4));
            end else if (shape == 1) begin
                add_noise($urandom_range(1, HEADER_LEN));
            end else begin
                add_noise(HEADER_LEN);
                if (shape == 2) begin
                    add_noise($urandom_range(1, 40));
                end else begin
                    repeat ($urandom_range(0, 8)) add_record(code);
                end
                // Cut some messages at a random byte
                if (shape >= 7) begin
                    cut = $urandom_range(HEADER_LEN, msg_bytes.size());
                    while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
                end
            end
            send_message(reconfig, code);
        end

        // Drain the result side, then allow for the output latency
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/dos_pkg.sv
hw/rtl/dos_parser.sv
hw/rtl/dhcp_option_scanner_unit.sv
hw/rtl/dos_checker.sv
verif/dhcp_option_scanner_unit_tb.sv
